// ===== rtl/wwlt_pkg.sv =====
package wwlt_pkg;

  // Operation codes carried in the op field of a request.
  localparam logic [2:0] OP_REQ_ONE = 3'd0;
  localparam logic [2:0] OP_REQ_TWO = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_TICK    = 3'd3;
  localparam logic [2:0] OP_SCAN    = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_FREE     = 3'd0;
  localparam logic [2:0] ST_WOUND    = 3'd1;
  localparam logic [2:0] ST_WAIT     = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_RELEASED = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  localparam logic [15:0] TIMEOUT_RESET = 16'd10;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  tool_a;
    logic [7:0]  tool_b;
    logic [15:0] client;
  } wwlt_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        granted;
    logic [15:0] wounded_owner;
    logic [6:0]  freed_count;
  } wwlt_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_RD_LO,
    S_RD_HI,
    S_DECIDE,
    S_WR_HI,
    S_SCAN
  } wwlt_state_t;

  typedef struct packed {
    logic capture;
    logic rd_lo;
    logic rd_hi;
    logic decide;
    logic wr_hi;
    logic release_tool;
    logic tick;
    logic scan_init;
    logic scan_step;
    logic load_res;
    logic finish;
  } wwlt_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       valid;
    logic       grant;
    logic       scan_last;
  } wwlt_stat_t;

endpackage

// ===== rtl/wound_wait_lock_table.sv =====
// Lock table over TOOLS tools with wound-wait preemption. Pulse start with a
// request while busy is low; one result appears on rsp, flagged by done for
// exactly one cycle, and cannot be held off, so capture it on that cycle. A
// single-tool request reads its entry and decides, a pair reads both and
// writes the upper one after a grant, release, tick and invalid ops end at
// dispatch, and a timeout scan reads each entry in turn: owner ids and grant
// times sit in a single-port table read one entry per cycle. A new request
// may be started in the cycle that done is shown. The timeout register may be
// written through cfg_we and cfg_data whenever no request is in flight.
module wound_wait_lock_table #(
  parameter int TOOLS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  wwlt_pkg::wwlt_req_t req,
  output logic                done,
  output wwlt_pkg::wwlt_rsp_t rsp,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data
);
  import wwlt_pkg::*;

  wwlt_cmd_t  cmd;
  wwlt_stat_t stat;

  wwlt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  wwlt_dp #(
    .TOOLS (TOOLS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat),
    .done     (done),
    .rsp      (rsp)
  );

  // Every result belongs to a request that was still in flight in the previous cycle.
  a_done_follows_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in flight");

  a_grant_status: assert property (@(posedge clk) disable iff (rst)
    done && rsp.granted |-> (rsp.status == ST_FREE || rsp.status == ST_WOUND))
    else $error("granted result with a non-grant status");

  a_wound_owner: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.status != ST_WOUND) |-> (rsp.wounded_owner == 16'd0))
    else $error("wounded owner reported without a wound");

  a_freed_scan_only: assert property (@(posedge clk) disable iff (rst)
    done && (rsp.freed_count != 7'd0) |-> (rsp.status == ST_DONE))
    else $error("freed count reported outside a scan");

endmodule

// ===== rtl/wwlt_ctrl.sv =====
module wwlt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  wwlt_pkg::wwlt_stat_t stat,
  output wwlt_pkg::wwlt_cmd_t  cmd,
  output logic                busy
);
  import wwlt_pkg::*;

  wwlt_state_t state;
  wwlt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.op) inside
          OP_REQ_ONE, OP_REQ_TWO: begin
            if (stat.valid) begin
              state_next = S_RD_LO;
            end else begin
              cmd.load_res = 1'b1;
              cmd.finish   = 1'b1;
              state_next   = S_IDLE;
            end
          end
          OP_RELEASE: begin
            cmd.release_tool = 1'b1;
            cmd.load_res     = 1'b1;
            cmd.finish       = 1'b1;
            state_next       = S_IDLE;
          end
          OP_TICK: begin
            cmd.tick     = 1'b1;
            cmd.load_res = 1'b1;
            cmd.finish   = 1'b1;
            state_next   = S_IDLE;
          end
          OP_SCAN: begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
          default: begin
            cmd.load_res = 1'b1;
            cmd.finish   = 1'b1;
            state_next   = S_IDLE;
          end
        endcase
      end
      S_RD_LO: begin
        cmd.rd_lo  = 1'b1;
        state_next = (stat.op == OP_REQ_TWO) ? S_RD_HI : S_DECIDE;
      end
      S_RD_HI: begin
        cmd.rd_hi  = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide   = 1'b1;
        cmd.load_res = 1'b1;
        if (stat.op == OP_REQ_TWO && stat.grant) begin
          state_next = S_WR_HI;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WR_HI: begin
        cmd.wr_hi  = 1'b1;
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          cmd.load_res = 1'b1;
          cmd.finish   = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = rst || (state != S_IDLE);

endmodule

// ===== rtl/wwlt_dp.sv =====
module wwlt_dp #(
  parameter int TOOLS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wwlt_pkg::wwlt_req_t  req,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  input  wwlt_pkg::wwlt_cmd_t  cmd,
  output wwlt_pkg::wwlt_stat_t stat,
  output logic                 done,
  output wwlt_pkg::wwlt_rsp_t  rsp
);
  import wwlt_pkg::*;

  localparam int IW = $clog2(TOOLS);
  localparam int CW = $clog2(TOOLS + 1);
  localparam int EW = 48;

  // Each entry holds the owner id in the upper 16 bits and the grant time in the lower 32.
  logic [EW-1:0] ent_mem [TOOLS];
  logic [EW-1:0] rd_data;
  logic [EW-1:0] lo_ent;

  logic [2:0]       op_r;
  logic [7:0]       lo_r;
  logic [7:0]       hi_r;
  logic [15:0]      who_r;
  logic [TOOLS-1:0] held;
  logic [31:0]      now_ticks;
  logic [15:0]      timeout;
  logic [CW-1:0]    cnt;
  logic [IW-1:0]    ev_idx;
  logic             ev_vld;
  logic [CW-1:0]    freed;

  logic [IW-1:0] lo_idx;
  logic [IW-1:0] hi_idx;
  logic          swap;
  logic          valid;
  logic          two;
  logic [EW-1:0] ent_lo;
  logic          held_lo;
  logic          held_hi;
  logic          wait_lo;
  logic          wait_hi;
  logic          grant;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [31:0]   age;
  logic          expire;
  logic [CW-1:0] freed_total;
  wwlt_rsp_t     res_next;

  assign swap = (req.op == OP_REQ_TWO) && (req.tool_b < req.tool_a);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= req.op;
      lo_r  <= swap ? req.tool_b : req.tool_a;
      hi_r  <= swap ? req.tool_a : req.tool_b;
      who_r <= req.client;
    end
  end

  assign lo_idx = lo_r[IW-1:0];
  assign hi_idx = hi_r[IW-1:0];
  assign two    = (op_r == OP_REQ_TWO);

  always_comb begin
    case (op_r) inside
      OP_REQ_ONE, OP_RELEASE: valid = (lo_r < 8'(TOOLS));
      OP_REQ_TWO:             valid = (lo_r != hi_r) && (hi_r < 8'(TOOLS));
      default:                valid = 1'b1;
    endcase
  end

  // Request decision: for a pair the lower entry was read first and parked.
  assign ent_lo  = two ? lo_ent : rd_data;
  assign held_lo = held[lo_idx];
  assign held_hi = two && held[hi_idx];
  assign wait_lo = held_lo && (who_r >= ent_lo[47:32]);
  assign wait_hi = held_hi && (who_r >= rd_data[47:32]);
  assign grant   = !(wait_lo || wait_hi);

  // Scan evaluates the entry whose read was issued in the previous cycle.
  assign age         = now_ticks - rd_data[31:0];
  assign expire      = ev_vld && held[ev_idx] && (age > {16'b0, timeout});
  assign freed_total = freed + CW'(expire);

  always_comb begin
    res_next = '0;
    case (op_r) inside
      OP_REQ_ONE, OP_REQ_TWO: begin
        if (!valid) begin
          res_next.status = ST_INVALID;
        end else if (!grant) begin
          res_next.status = ST_WAIT;
        end else begin
          res_next.granted = 1'b1;
          if (held_lo) begin
            res_next.status        = ST_WOUND;
            res_next.wounded_owner = ent_lo[47:32];
          end else if (held_hi) begin
            res_next.status        = ST_WOUND;
            res_next.wounded_owner = rd_data[47:32];
          end else begin
            res_next.status = ST_FREE;
          end
        end
      end
      OP_RELEASE: res_next.status = ST_RELEASED;
      OP_TICK:    res_next.status = ST_DONE;
      OP_SCAN: begin
        res_next.status      = ST_DONE;
        res_next.freed_count = 7'(freed_total);
      end
      default:    res_next.status = ST_INVALID;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = lo_idx;
    if (cmd.rd_lo) begin
      rd_en = 1'b1;
    end else if (cmd.rd_hi) begin
      rd_en   = 1'b1;
      rd_addr = hi_idx;
    end else if (cmd.scan_step && (cnt < CW'(TOOLS))) begin
      rd_en   = 1'b1;
      rd_addr = cnt[IW-1:0];
    end
  end

  assign wr_en   = (cmd.decide && grant) || cmd.wr_hi;
  assign wr_addr = cmd.wr_hi ? hi_idx : lo_idx;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_mem[wr_addr] <= {who_r, now_ticks};
    end
    if (rd_en) begin
      rd_data <= ent_mem[rd_addr];
    end
    if (cmd.rd_hi) begin
      lo_ent <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      now_ticks <= '0;
      timeout   <= TIMEOUT_RESET;
    end else begin
      if (cfg_we) begin
        timeout <= cfg_data;
      end
      if (cmd.tick) begin
        now_ticks <= now_ticks + 32'd1;
      end
      if (cmd.decide && grant) begin
        held[lo_idx] <= 1'b1;
        if (two) begin
          held[hi_idx] <= 1'b1;
        end
      end
      if (cmd.release_tool && valid) begin
        held[lo_idx] <= 1'b0;
      end
      if (cmd.scan_step && expire) begin
        held[ev_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      cnt    <= '0;
      ev_vld <= 1'b0;
      freed  <= '0;
    end else if (cmd.scan_step) begin
      freed  <= freed_total;
      ev_vld <= (cnt < CW'(TOOLS));
      ev_idx <= cnt[IW-1:0];
      if (cnt < CW'(TOOLS)) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      rsp <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  assign stat.op        = op_r;
  assign stat.valid     = valid;
  assign stat.grant     = grant;
  assign stat.scan_last = (cnt == CW'(TOOLS));

endmodule

// ===== dv/wound_wait_lock_table_tb.sv =====
module wound_wait_lock_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wwlt_pkg::*;

  localparam int TOOLS = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 325;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  wwlt_req_t req = '0;
  logic      done;
  wwlt_rsp_t rsp;
  logic      cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  // Mirror of the lock table used to work out each expected response.
  logic        held_m [TOOLS];
  logic [15:0] owner_m [TOOLS];
  logic [31:0] since_m [TOOLS];
  logic [31:0] ticks_m;
  logic [15:0] timeout_m;

  wwlt_rsp_t lock_outcomes[$];
  int        fail_count = 0;
  int        send_idle_pct = 35;
  int        stall_cycles = 0;
  bit        start_up = 1'b0;

  wound_wait_lock_table #(.TOOLS(TOOLS)) u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .req     (req),
    .done    (done),
    .rsp     (rsp),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void claim_tool(int t, logic [15:0] who);
    held_m[t] = 1'b1;
    owner_m[t] = who;
    since_m[t] = ticks_m;
  endfunction

  function automatic void drop_tool(int t);
    held_m[t] = 1'b0;
    owner_m[t] = '0;
    since_m[t] = '0;
  endfunction

  function automatic bit must_wait(int t, logic [15:0] who);
    return held_m[t] && who >= owner_m[t];
  endfunction

  function automatic wwlt_rsp_t apply_lock_op(wwlt_req_t r);
    wwlt_rsp_t o;
    int        ta;
    int        tb;
    int        lo;
    int        hi;
    o = '0;
    o.status = ST_INVALID;
    ta = int'(r.tool_a);
    tb = int'(r.tool_b);
    lo = (ta < tb) ? ta : tb;
    hi = (ta < tb) ? tb : ta;
    case (r.op)
      OP_REQ_ONE: begin
        if (ta < TOOLS) begin
          if (!held_m[ta]) begin
            claim_tool(ta, r.client);
            o.status = ST_FREE;
            o.granted = 1'b1;
          end else if (r.client < owner_m[ta]) begin
            o.wounded_owner = owner_m[ta];
            claim_tool(ta, r.client);
            o.status = ST_WOUND;
            o.granted = 1'b1;
          end else begin
            o.status = ST_WAIT;
          end
        end
      end
      OP_REQ_TWO: begin
        if (lo != hi && hi < TOOLS) begin
          if (must_wait(lo, r.client) || must_wait(hi, r.client)) begin
            o.status = ST_WAIT;
          end else begin
            o.status = ST_FREE;
            // The lower tool's holder wins when both are wounded.
            if (held_m[hi]) begin
              o.wounded_owner = owner_m[hi];
              o.status = ST_WOUND;
            end
            if (held_m[lo]) begin
              o.wounded_owner = owner_m[lo];
              o.status = ST_WOUND;
            end
            claim_tool(lo, r.client);
            claim_tool(hi, r.client);
            o.granted = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        if (ta < TOOLS) drop_tool(ta);
        o.status = ST_RELEASED;
      end
      OP_TICK: begin
        ticks_m = ticks_m + 32'd1;
        o.status = ST_DONE;
      end
      OP_SCAN: begin
        for (int i = 0; i < TOOLS; i++) begin
          if (held_m[i] && (ticks_m - since_m[i]) > {16'd0, timeout_m}) begin
            drop_tool(i);
            o.freed_count = o.freed_count + 7'd1;
          end
        end
        o.status = ST_DONE;
      end
      default: o.status = ST_INVALID;
    endcase
    return o;
  endfunction

  // Sampled on the falling edge, where every signal has settled since the
  // last rising edge.
  always @(negedge clk) begin
    wwlt_rsp_t exp_rsp;
    if (!rst && done) begin
      if (lock_outcomes.size() == 0) begin
        $error("result with no transfer pending: status %0d", rsp.status);
        fail_count++;
      end else begin
        exp_rsp = lock_outcomes.pop_front();
        if (rsp.status !== exp_rsp.status) begin
          $error("status: expected %0d, actual %0d", exp_rsp.status, rsp.status);
          fail_count++;
        end
        if (rsp.granted !== exp_rsp.granted) begin
          $error("granted: expected %0d, actual %0d", exp_rsp.granted, rsp.granted);
          fail_count++;
        end
        if (rsp.wounded_owner !== exp_rsp.wounded_owner) begin
          $error("wounded_owner: expected %0d, actual %0d",
                 exp_rsp.wounded_owner, rsp.wounded_owner);
          fail_count++;
        end
        if (rsp.freed_count !== exp_rsp.freed_count) begin
          $error("freed_count: expected %0d, actual %0d",
                 exp_rsp.freed_count, rsp.freed_count);
          fail_count++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("wound_wait_lock_table test failed");
        $finish;
      end
    end
  end

  task automatic drop_start();
    if (start_up) begin
      start <= 1'b0;
      start_up = 1'b0;
    end
  endtask

  task automatic send_req(input logic [2:0] op, input logic [7:0] ta,
                          input logic [7:0] tb, input logic [15:0] who);
    wwlt_req_t r;
    int        gap;
    bit        ready;
    r.op = op;
    r.tool_a = ta;
    r.tool_b = tb;
    r.client = who;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      drop_start();
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    start_up = 1'b1;
    do begin
      @(negedge clk);
      ready = !busy;
      @(posedge clk);
    end while (!ready);
    lock_outcomes.push_back(apply_lock_op(r));
  endtask

  task automatic wait_drained();
    drop_start();
    while (lock_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    wait_drained();
    cfg_data <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout_m = value;
  endtask

  task automatic test_single_tool();
    send_req(OP_REQ_ONE, 8'd0, 8'd0, 16'd100);
    send_req(OP_REQ_ONE, 8'd0, 8'd0, 16'd200);
    send_req(OP_REQ_ONE, 8'd0, 8'd0, 16'd100);
    send_req(OP_REQ_ONE, 8'd0, 8'd0, 16'd0);
    send_req(OP_REQ_ONE, 8'd7, 8'd255, 16'hFFFF);
    send_req(OP_REQ_ONE, 8'(TOOLS), 8'd0, 16'd1);
    send_req(OP_REQ_ONE, 8'd255, 8'd1, 16'd1);
  endtask

  task automatic test_tool_pairs();
    send_req(OP_REQ_TWO, 8'd3, 8'd3, 16'd5);
    send_req(OP_REQ_TWO, 8'd2, 8'(TOOLS), 16'd5);
    send_req(OP_REQ_TWO, 8'd255, 8'd1, 16'd5);
    send_req(OP_REQ_TWO, 8'd7, 8'd0, 16'd5);
    send_req(OP_REQ_TWO, 8'd1, 8'd2, 16'd50);
    send_req(OP_REQ_TWO, 8'd2, 8'd1, 16'd40);
    send_req(OP_REQ_TWO, 8'd7, 8'd3, 16'd9);
  endtask

  task automatic test_release_and_unused_ops();
    send_req(OP_RELEASE, 8'd1, 8'd0, 16'd77);
    send_req(OP_RELEASE, 8'd5, 8'd0, 16'd77);
    send_req(OP_RELEASE, 8'd200, 8'd0, 16'd77);
    send_req(3'd5, 8'd0, 8'd1, 16'd1);
    send_req(3'd6, 8'd2, 8'd3, 16'd1);
    send_req(3'd7, 8'd4, 8'd5, 16'd1);
  endtask

  task automatic test_timeout_scan();
    // Age must be strictly above the limit, so nothing goes at age zero.
    write_timeout(16'd0);
    send_req(OP_SCAN, 8'd0, 8'd0, 16'd0);
    send_req(OP_TICK, 8'd0, 8'd0, 16'd0);
    send_req(OP_SCAN, 8'd0, 8'd0, 16'd0);
    write_timeout(16'hFFFF);
    send_req(OP_REQ_ONE, 8'd4, 8'd0, 16'd3);
    send_req(OP_TICK, 8'd0, 8'd0, 16'd0);
    send_req(OP_SCAN, 8'd0, 8'd0, 16'd0);
  endtask

  task automatic test_random_traffic(input logic [15:0] limit, input int idle_pct);
    logic [2:0]  op;
    logic [7:0]  ta;
    logic [7:0]  tb;
    logic [15:0] who;
    int          pick;
    write_timeout(limit);
    send_idle_pct = idle_pct;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      pick = $urandom_range(99);
      if (pick < 30) op = OP_REQ_ONE;
      else if (pick < 50) op = OP_REQ_TWO;
      else if (pick < 63) op = OP_RELEASE;
      else if (pick < 80) op = OP_TICK;
      else if (pick < 90) op = OP_SCAN;
      else op = 3'($urandom_range(7));
      ta = ($urandom_range(99) < 85) ? 8'($urandom_range(TOOLS - 1))
                                     : 8'($urandom_range(255));
      tb = ($urandom_range(99) < 85) ? 8'($urandom_range(TOOLS - 1))
                                     : 8'($urandom_range(255));
      if ($urandom_range(9) == 0) tb = ta;
      // A small pool of ids keeps collisions and wounds frequent.
      case ($urandom_range(9)) inside
        0: who = 16'd0;
        1: who = 16'hFFFF;
        [2:6]: who = 16'($urandom_range(1, 12));
        default: who = 16'($urandom_range(16'hFFFF));
      endcase
      send_req(op, ta, tb, who);
    end
  endtask

  initial begin
    for (int i = 0; i < TOOLS; i++) begin
      held_m[i] = 1'b0;
      owner_m[i] = '0;
      since_m[i] = '0;
    end
    ticks_m = '0;
    timeout_m = TIMEOUT_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_single_tool();
    test_tool_pairs();
    test_release_and_unused_ops();
    test_timeout_scan();
    test_random_traffic(16'd3, 35);
    test_random_traffic(16'd0, 35);
    test_random_traffic(16'hFFFF, 64);
    test_random_traffic(16'd7, 64);
    test_random_traffic(16'd1, 0);
    test_random_traffic(16'd20, 0);
    wait_drained();
    repeat (TOOLS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("wound_wait_lock_table test passed");
    end else begin
      $display("wound_wait_lock_table test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wwlt_pkg.sv
rtl/wwlt_ctrl.sv
rtl/wwlt_dp.sv
rtl/wound_wait_lock_table.sv
dv/wound_wait_lock_table_tb.sv
